// File: hw/rtl/pes_hdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pes_hdr_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned TsW     = 33;
   localparam int unsigned RspDataW = 128;

   // One input word: the byte and its start-of-packet marker.
   typedef struct packed {
      logic             first_byte;
      logic [ByteW-1:0] data_byte;
   } item_type;

   // One parsed header, lowest field last so that it packs from bit 0 up.
   typedef struct packed {
      logic [TsW-1:0] dts_value;
      logic [TsW-1:0] pts_value;
      logic [1:0]     ts_flags;
      logic [5:0]     header_length;
      logic [15:0]    packet_length;
      logic [7:0]     stream_id;
      logic [23:0]    start_code;
   } result_type;

   localparam int unsigned ResultW = $bits(result_type);

endpackage

`default_nettype wire

// File: hw/rtl/pes_hdr_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module pes_hdr_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire pes_hdr_pkg::item_type  item,
   output logic                        emit,
   output pes_hdr_pkg::result_type     result
);

   localparam logic [7:0] IdPsm      = 8'hBC;
   localparam logic [7:0] IdPadding  = 8'hBE;
   localparam logic [7:0] IdPrivate2 = 8'hBF;
   localparam logic [7:0] IdEcm      = 8'hF0;
   localparam logic [7:0] IdEmm      = 8'hF1;
   localparam logic [7:0] IdDsmcc    = 8'hF2;
   localparam logic [7:0] IdH2221E   = 8'hF8;
   localparam logic [7:0] IdPsd      = 8'hFF;

   localparam logic [5:0] PosStreamId = 6'd3;
   localparam logic [5:0] PosLenHi    = 6'd4;
   localparam logic [5:0] PosLenLo    = 6'd5;
   localparam logic [5:0] PosFlags    = 6'd7;
   localparam logic [5:0] PosOptStart = 6'd8;
   localparam logic [5:0] PosPtsFirst = 6'd9;
   localparam logic [5:0] PosPtsLast  = 6'd13;
   localparam logic [5:0] PosDtsFirst = 6'd14;
   localparam logic [5:0] PosDtsLast  = 6'd18;
   localparam logic [5:0] SpecialLen  = 6'd6;

   function automatic logic is_special(input logic [7:0] id);
      is_special = (id == IdPsm) || (id == IdPadding) || (id == IdPrivate2) ||
                   (id == IdEcm) || (id == IdEmm) || (id == IdDsmcc) ||
                   (id == IdH2221E) || (id == IdPsd);
   endfunction

   // Header length from the optional-field flags byte alone.
   function automatic logic [5:0] base_length(input logic [7:0] f);
      logic [5:0] n;
      n = 6'd9;
      if (f[7] && f[6]) n = n + 6'd10;
      else if (f[7])    n = n + 6'd5;
      if (f[5]) n = n + 6'd6;
      if (f[4]) n = n + 6'd3;
      if (f[2]) n = n + 6'd1;
      if (f[1]) n = n + 6'd2;
      base_length = n;
   endfunction

   // Contribution of byte k of a five-byte time stamp field.
   function automatic logic [32:0] ts_part(input logic [2:0] k, input logic [7:0] b);
      logic [32:0] v;
      v = '0;
      unique case (k)
         3'd0:    v[32:30] = b[3:1];
         3'd1:    v[29:22] = b;
         3'd2:    v[21:15] = b[7:1];
         3'd3:    v[14:7]  = b;
         default: v[6:0]   = b[7:1];
      endcase
      ts_part = v;
   endfunction

   logic [5:0]  pos_ff,   pos_in;
   logic [23:0] sc_ff,    sc_in;
   logic [7:0]  sid_ff,   sid_in;
   logic [15:0] len_ff,   len_in;
   logic [7:0]  flags_ff, flags_in;
   logic [32:0] pts_ff,   pts_in;
   logic [32:0] dts_ff,   dts_in;
   logic [5:0]  lsum_ff,  lsum_in;
   logic        done_ff,  done_in;

   logic [7:0]  b;
   logic [5:0]  p;
   logic [5:0]  base;
   logic [5:0]  ext_len;
   logic [5:0]  pts_k;
   logic [5:0]  dts_k;
   logic        ext_pending;

   always_comb begin
      b       = item.data_byte;
      emit    = 1'b0;
      // A first-byte marker restarts the parse from cleared state.
      pos_in   = item.first_byte ? '0 : pos_ff;
      sc_in    = item.first_byte ? '0 : sc_ff;
      sid_in   = item.first_byte ? '0 : sid_ff;
      len_in   = item.first_byte ? '0 : len_ff;
      flags_in = item.first_byte ? '0 : flags_ff;
      pts_in   = item.first_byte ? '0 : pts_ff;
      dts_in   = item.first_byte ? '0 : dts_ff;
      lsum_in  = item.first_byte ? '0 : lsum_ff;
      done_in  = item.first_byte ? 1'b0 : done_ff;
      p        = pos_in;
      base     = base_length(flags_in);
      ext_len  = base + 6'd1 + (b[7] ? 6'd16 : 6'd0) + {5'd0, b[6]} +
                 (b[5] ? 6'd2 : 6'd0) + (b[4] ? 6'd2 : 6'd0) + (b[0] ? 6'd2 : 6'd0);
      pts_k    = p - PosPtsFirst;
      dts_k    = p - PosDtsFirst;
      ext_pending = 1'b0;

      if (!done_in) begin
         pos_in = p + 6'd1;
         if (p < PosStreamId) begin
            sc_in = {sc_in[15:0], b};
         end else if (p == PosStreamId) begin
            sid_in = b;
         end else if (p == PosLenHi || p == PosLenLo) begin
            len_in = {len_in[7:0], b};
            if (p == PosLenLo && is_special(sid_in)) begin
               lsum_in = SpecialLen;
               done_in = 1'b1;
               emit    = 1'b1;
            end
         end else if (p == PosFlags) begin
            flags_in = b;
            lsum_in  = base_length(b);
         end else if (p >= PosOptStart) begin
            if (flags_in[7] && p >= PosPtsFirst && p <= PosPtsLast)
               pts_in = pts_in | ts_part(pts_k[2:0], b);
            if (flags_in[7] && flags_in[6] && p >= PosDtsFirst && p <= PosDtsLast)
               dts_in = dts_in | ts_part(dts_k[2:0], b);
            // Extension flags byte sits right after the flag-driven fields.
            if (flags_in[0] && p == base)
               lsum_in = ext_len;
            ext_pending = flags_in[0] && (p < base);
            if (!ext_pending && ({1'b0, p} + 7'd1 == {1'b0, lsum_in})) begin
               done_in = 1'b1;
               emit    = 1'b1;
            end
         end
      end

      result.start_code    = sc_in;
      result.stream_id     = sid_in;
      result.packet_length = len_in;
      result.header_length = lsum_in;
      result.ts_flags      = flags_in[7:6];
      result.pts_value     = pts_in;
      result.dts_value     = dts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b1;
      end else if (fire) begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
      if (fire) begin
         sc_ff    <= sc_in;
         sid_ff   <= sid_in;
         len_ff   <= len_in;
         flags_ff <= flags_in;
         pts_ff   <= pts_in;
         dts_ff   <= dts_in;
         lsum_ff  <= lsum_in;
      end
   end

   a_emit_len_min: assert property (@(posedge clock) disable iff (reset)
      fire && emit |-> result.header_length >= SpecialLen)
      else $error("header length below minimum on emit");

   a_emit_sets_done: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> done_ff)
      else $error("parser not idle after emitting a header");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      done_ff && !item.first_byte |-> !emit)
      else $error("result emitted while idle");

endmodule

`default_nettype wire

// File: hw/rtl/pes_header_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A header's closing word passes the input register, then the result register, to rsp_tvalid.
// Throughput: one word per cycle; only rsp_tready backpressure stalls it.
// The rate is set by the input register feeding the single-pass parse step.
// Reset: synchronous, active high; the parser then ignores words until a
// word with the first-byte flag arrives, and both stages are empty.
module pes_header_parser_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] first_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata    // [23:0] start_code, [31:24] stream_id,
                                          // [47:32] packet_length, [53:48] header_length,
                                          // [55:54] ts_flags, [88:56] pts_value,
                                          // [121:89] dts_value, [127:122] zero
);

   // Input register: hold the accepted word until the parse step takes it.
   logic                    in_vld_ff, in_vld_in;
   pes_hdr_pkg::item_type   in_item_ff, in_item_in;

   // Result register: park a finished header until the sink takes it.
   logic                    rsp_vld_ff, rsp_vld_in;
   pes_hdr_pkg::result_type rsp_res_ff, rsp_res_in;

   logic                    out_ready;
   logic                    fire;
   logic                    emit;
   pes_hdr_pkg::result_type result;

   // Advance the input word whenever the result register can take a result.
   assign out_ready  = !rsp_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_ready;
   assign req_tready = !in_vld_ff || out_ready;

   always_comb begin
      in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
      in_item_in = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_item_in.data_byte  = req_tdata;
         in_item_in.first_byte = req_tuser;
      end
      rsp_vld_in = out_ready ? (fire && emit) : rsp_vld_ff;
      rsp_res_in = (fire && emit) ? result : rsp_res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      in_item_ff <= in_item_in;
      rsp_res_ff <= rsp_res_in;
   end

   pes_hdr_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .emit   (emit),
      .result (result)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(pes_hdr_pkg::RspDataW - pes_hdr_pkg::ResultW)'(0), rsp_res_ff};

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !out_ready |=> in_vld_ff && $stable(in_item_ff))
      else $error("input word lost while parse stage stalled");

   a_in_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_vld_ff)
      else $error("accepted word not registered");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped while sink stalled");

endmodule

`default_nettype wire
